// ----- src/rat_pkg.sv -----
// shared constants, types and command/status structs for the rotation angle tracker
package rat_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int MAX_DIVISIONS = 1024;
  localparam int TIME_BITS     = 32;

  localparam int UNW_W  = 32;
  localparam int FILT_W = 40;
  localparam int COEF_W = 16;
  localparam int DIV_W  = 11;
  localparam int IDX_W  = 10;
  localparam int TM_W   = ANGLE_BITS + 8;
  localparam int MAG_W  = 31;
  localparam int DVD_W  = MAG_W + TIME_BITS;
  localparam int ACC_W  = 64;
  localparam int MPL_W  = (TIME_BITS > COEF_W + 1) ? TIME_BITS : COEF_W + 1;
  localparam int CNT_W  = $clog2(DVD_W + 1);

  localparam logic [1:0] REG_COEFF = 2'd0;
  localparam logic [1:0] REG_TRIM  = 2'd1;
  localparam logic [1:0] REG_DIVS  = 2'd2;

  typedef struct packed {
    logic load;
    logic samp_unwrap;
    logic samp_setup;
    logic tick_setup;
    logic mul_step;
    logic samp_fin;
    logic div_init;
    logic div_step;
    logic tmod_calc;
    logic scale_calc;
    logic out_load;
    logic upd;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic dt_zero;
  } stat_t;

endpackage

// ----- src/rat_ctrl.sv -----
// sequencing state machine for samples and ticks
module rat_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  rat_pkg::stat_t st,
  output rat_pkg::cmd_t  cmd
);
  import rat_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_SPREP = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_SFIN  = 4'd4;
  localparam logic [3:0] S_DIVI  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_TMOD  = 4'd7;
  localparam logic [3:0] S_SCALE = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  localparam logic [CNT_W-1:0] MUL_S_LAST = CNT_W'(COEF_W);
  localparam logic [CNT_W-1:0] MUL_T_LAST = CNT_W'(TIME_BITS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(DVD_W - 1);

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             upd, upd_next;
  logic             mvalid_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    upd_next    = upd;
    mvalid_next = m_tvalid && !m_tready;
    cmd         = '0;
    cmd.upd     = upd;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        cnt_next = '0;
        if (!st.is_tick) begin
          cmd.samp_unwrap = 1'b1;
          state_next      = S_SPREP;
        end else if (st.dt_zero) begin
          upd_next   = 1'b0;
          state_next = S_OUT;
        end else begin
          cmd.tick_setup = 1'b1;
          upd_next       = 1'b1;
          state_next     = S_MUL;
        end
      end
      S_SPREP: begin
        cmd.samp_setup = 1'b1;
        state_next     = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (!st.is_tick && cnt == MUL_S_LAST) begin
          state_next = S_SFIN;
        end else if (st.is_tick && cnt == MUL_T_LAST) begin
          state_next = S_DIVI;
        end
      end
      S_SFIN: begin
        cmd.samp_fin = 1'b1;
        state_next   = S_IDLE;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == DIV_LAST) state_next = S_TMOD;
      end
      S_TMOD: begin
        cmd.tmod_calc = 1'b1;
        state_next    = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale_calc = 1'b1;
        state_next     = S_OUT;
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          mvalid_next  = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      upd      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      upd      <= upd_next;
      m_tvalid <= mvalid_next;
    end
  end

endmodule

// ----- src/rat_dp.sv -----
// datapath: config registers, unwrap, filter, shift-add multiplier, divider, slot map
module rat_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [15:0]                   cfg_data,
  input  logic                          in_op,
  input  logic [15:0]                   in_angle,
  input  logic [31:0]                   in_time,
  input  rat_pkg::cmd_t                 cmd,
  output rat_pkg::stat_t                st,
  output logic [rat_pkg::IDX_W-1:0]     out_index,
  output logic [rat_pkg::IDX_W-1:0]     out_column,
  output logic                          out_upd
);
  import rat_pkg::*;

  logic [COEF_W-1:0]    coeff;
  logic [15:0]          trim;
  logic [DIV_W-1:0]     divs;
  logic                 op;
  logic [ANGLE_BITS-1:0] angle;
  logic [TIME_BITS-1:0] tnow;
  logic [UNW_W-1:0]     unw;
  logic [FILT_W-1:0]    fc, fp;
  logic [TIME_BITS-1:0] tc, tp;
  logic [IDX_W-1:0]     held;
  logic [ACC_W-1:0]     acc, mcand;
  logic [MPL_W-1:0]     mplier;
  logic [DVD_W-1:0]     nq;
  logic [TIME_BITS-1:0] rem;
  logic                 neg;
  logic [TM_W-1:0]      tmod;
  logic [IDX_W-1:0]     idx;

  logic [ANGLE_BITS-1:0] step;
  logic [FILT_W-1:0]     dval, delta, dmag, qv, sv;
  logic [MAG_W-1:0]      mag;
  logic [TIME_BITS-1:0]  dt, el;
  logic [TIME_BITS:0]    trial;
  logic                  ge;
  logic [DIV_W-1:0]      div_eff;
  logic [TM_W+DIV_W-1:0] prod;
  logic [IDX_W-1:0]      idx_sel;
  logic [DIV_W-1:0]      col_w;

  assign step  = angle - unw[ANGLE_BITS-1:0];
  assign dval  = {unw, 8'b0} - fc;
  assign delta = fc - fp;
  assign dmag  = delta[FILT_W-1] ? (~delta + 1'b1) : delta;
  assign mag   = (dmag > FILT_W'(32'h7FFF_FFFF)) ? {MAG_W{1'b1}} : dmag[MAG_W-1:0];
  assign dt    = tc - tp;
  assign el    = tnow - tc;
  assign trial = {rem, nq[DVD_W-1]};
  assign ge    = trial >= {1'b0, dt};
  assign qv    = nq[FILT_W-1:0];
  assign sv    = fc + (neg ? (~qv + 1'b1) : qv) + {8'b0, trim, 8'b0};
  assign prod  = tmod * div_eff;

  always_comb begin
    if (divs == '0) div_eff = DIV_W'(1);
    else if (divs > DIV_W'(MAX_DIVISIONS)) div_eff = DIV_W'(MAX_DIVISIONS);
    else div_eff = divs;
  end

  assign idx_sel = cmd.upd ? idx : held;
  assign col_w   = ({1'b0, idx_sel} < div_eff) ? (div_eff - 1'b1 - {1'b0, idx_sel}) : '0;

  assign st.is_tick = op;
  assign st.dt_zero = (dt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= COEF_W'(62259);
      trim  <= 16'd20026;
      divs  <= DIV_W'(333);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEFF: coeff <= cfg_data;
        REG_TRIM:  trim  <= cfg_data;
        REG_DIVS:  divs  <= cfg_data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unw  <= '0;
      fc   <= '0;
      fp   <= '0;
      tc   <= '0;
      tp   <= '0;
      held <= '0;
    end else begin
      if (cmd.samp_unwrap) unw <= unw + {{(UNW_W-ANGLE_BITS){step[ANGLE_BITS-1]}}, step};
      if (cmd.samp_fin) begin
        fp <= fc;
        fc <= fc + acc[FILT_W+15:16];
        tp <= tc;
        tc <= tnow;
      end
      if (cmd.out_load && cmd.upd) held <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= in_op;
      angle <= in_angle[ANGLE_BITS-1:0];
      tnow  <= in_time[TIME_BITS-1:0];
    end
    if (cmd.samp_setup) begin
      mcand  <= {{(ACC_W-FILT_W){dval[FILT_W-1]}}, dval};
      mplier <= MPL_W'(17'h10000 - {1'b0, coeff});
      acc    <= ACC_W'(32768);
    end else if (cmd.tick_setup) begin
      mcand  <= ACC_W'(mag);
      mplier <= MPL_W'(el);
      acc    <= '0;
      neg    <= delta[FILT_W-1];
    end else if (cmd.mul_step) begin
      if (mplier[0]) acc <= acc + mcand;
      mcand  <= {mcand[ACC_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[MPL_W-1:1]};
    end
    if (cmd.div_init) begin
      nq  <= acc[DVD_W-1:0];
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? TIME_BITS'(trial - {1'b0, dt}) : trial[TIME_BITS-1:0];
      nq  <= {nq[DVD_W-2:0], ge};
    end
    if (cmd.tmod_calc)  tmod <= sv[TM_W-1:0];
    if (cmd.scale_calc) idx  <= prod[TM_W+IDX_W-1:TM_W];
    if (cmd.out_load) begin
      out_index  <= idx_sel;
      out_column <= col_w[IDX_W-1:0];
      out_upd    <= cmd.upd;
    end
  end

endmodule

// ----- src/rotation_angle_tracker.sv -----
// top level: rotation angle tracker, controller plus datapath
// a sample request runs unwrap, a 17-step shift-add filter multiply, then the update
// a tick request with new samples runs a 32-step multiply of angle change by elapsed
//   time, a 63-step restoring divide by the sample interval, then trim and slot scaling
// a tick with equal sample times skips to output; results sit in an output register
// synchronous active-high reset restores register defaults and clears all tracking state
module rotation_angle_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // angle[15:0], time_us[47:16]
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // angle_index[9:0], column[19:10], zero pad
  output logic        m_tuser,   // updated
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rat_pkg::*;

  cmd_t             cmd;
  stat_t            st;
  logic [IDX_W-1:0] out_index;
  logic [IDX_W-1:0] out_column;

  // one request in flight; input is taken only when the sequencer is idle
  rat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // arithmetic and all tracking state
  rat_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_op      (s_tuser),
    .in_angle   (s_tdata[15:0]),
    .in_time    (s_tdata[47:16]),
    .cmd        (cmd),
    .st         (st),
    .out_index  (out_index),
    .out_column (out_column),
    .out_upd    (m_tuser)
  );

  // pack result fields, index lowest
  assign m_tdata = {4'b0, out_column, out_index};

  // the sequencer always leaves idle right after taking a request
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted but sequencer stayed idle");

  // a sample request never produces a result
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tuser) |=> ##1 !$rose(m_tvalid))
    else $error("sample request produced a result");

  // a result is loaded only while no new request is taken
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared from idle state");

endmodule
